/* hdl/sliding_window_median_alert_top_defines.svh */
// assertion macros for the sliding window median alert block
// used by the top level only; no other dependencies
`ifndef SLIDING_WINDOW_MEDIAN_ALERT_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_ALERT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define SWMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SWMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWMA_ASSERT(lbl, prop, msg)
`define SWMA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/swma_pkg.sv */
// shared types and constants for the sliding window median alert block
// no dependencies
package swma_pkg;

    localparam int VALUE_LEVELS = 256;
    localparam int LEVEL_W      = $clog2(VALUE_LEVELS);
    localparam int WINDOW_MAX   = 1024;
    localparam int RING_AW      = $clog2(WINDOW_MAX);
    localparam int WIN_W        = 11;
    localparam int COUNT_W      = 11;
    localparam int SEEN_W       = COUNT_W + 1;
    localparam int DM_W         = LEVEL_W + 1;
    localparam int TOTAL_W      = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OLD_RD,
        ST_OLD_HRD,
        ST_OLD_WR,
        ST_NEW_RD,
        ST_NEW_WR,
        ST_DONE
    } swma_state_t;

    // one access to the histogram store per cycle
    typedef struct packed {
        logic               clear;
        logic               wr_en;
        logic [LEVEL_W-1:0] addr;
        logic [COUNT_W-1:0] wr_data;
    } hist_req_t;

endpackage

/* hdl/swma_sample_if.sv */
// input sample channel: valid/ready with sample and start flag
// depends on swma_pkg
interface swma_sample_if;
    logic                        valid;
    logic                        ready;
    logic [swma_pkg::LEVEL_W-1:0] sample;
    logic                        start_of_sequence;

    modport source (output valid, output sample, output start_of_sequence, input ready);
    modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

/* hdl/swma_result_if.sv */
// result channel: valid/ready with alert flag, doubled median and alert total
// depends on swma_pkg
interface swma_result_if;
    logic                         valid;
    logic                         ready;
    logic                         alert;
    logic [swma_pkg::DM_W-1:0]    doubled_median;
    logic [swma_pkg::TOTAL_W-1:0] alert_total;

    modport source (output valid, output alert, output doubled_median,
                    output alert_total, input ready);
    modport sink   (input valid, input alert, input doubled_median,
                    input alert_total, output ready);
endinterface

/* hdl/swma_cfg_if.sv */
// configuration write channel carrying the window length
// depends on swma_pkg
interface swma_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [swma_pkg::WIN_W-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

/* hdl/swma_hist.sv */
// histogram store: one count per sample level, registered read,
// per-bin valid bits so a clear empties every bin together; depends on swma_pkg
module swma_hist (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swma_pkg::hist_req_t          req,
    output logic [swma_pkg::COUNT_W-1:0] q
);
    import swma_pkg::*;

    logic [COUNT_W-1:0]      mem [VALUE_LEVELS];
    logic [VALUE_LEVELS-1:0] valid_reg;
    logic [COUNT_W-1:0]      mem_q_reg;
    logic                    vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        mem_q_reg <= mem[req.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            vld_q_reg <= valid_reg[req.addr];
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
        end
    end

    // a bin never written since the last clear counts as empty
    assign q = vld_q_reg ? mem_q_reg : '0;

endmodule

/* hdl/sliding_window_median_alert_top.sv */
// sliding window median alert: top level with sequencer, sample ring and scan unit
// depends on swma_pkg, the three channel interfaces, swma_hist and the defines header
//
// channel   dir   payload                                      request when
// cfg       in    window_length[10:0]                          valid & ready
// samples   in    sample[7:0], start_of_sequence               valid & ready
// results   out   alert, doubled_median[8:0], alert_total[31:0] valid & ready
//
// a sample that only fills the window goes from its request through NEW_RD and NEW_WR back to ready
// any other sample scans at most 256 bins, then passes OLD_RD, OLD_HRD, OLD_WR, NEW_RD, NEW_WR
// and DONE; the scan reads one histogram bin per cycle through the single histogram port
// no clearing pass: histogram bins carry valid bits, cleared in the request cycle
// samples is not ready while an item is in progress; a full result slot stalls it at the end
// cfg is taken only when idle and wins over a sample; a write restarts the window
`include "sliding_window_median_alert_top_defines.svh"

module sliding_window_median_alert_top (
    input  logic           clk,
    input  logic           rst_n,
    swma_cfg_if.sink       cfg,
    swma_sample_if.sink    samples,
    swma_result_if.source  results
);
    import swma_pkg::*;

    swma_state_t         state_reg, state_next;
    logic [WIN_W-1:0]    win_len_reg, win_len_next;
    logic [RING_AW-1:0]  ring_pos_reg, ring_pos_next;
    logic [WIN_W-1:0]    fill_reg, fill_next;
    logic [TOTAL_W-1:0]  alert_cnt_reg, alert_cnt_next;
    logic                filling_reg, filling_next;
    logic [LEVEL_W:0]    scan_next_reg, scan_next_next;
    logic                scan_prime_reg, scan_prime_next;
    logic                second_reg, second_next;
    logic                out_valid_reg, out_valid_next;

    logic [LEVEL_W-1:0]  smp_reg, smp_next;
    logic [LEVEL_W-1:0]  cur_idx_reg, cur_idx_next;
    logic [LEVEL_W-1:0]  lo_reg, lo_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic [DM_W-1:0]     dm_reg, dm_next;
    logic                alert_reg, alert_next;
    logic                out_alert_reg, out_alert_next;
    logic [DM_W-1:0]     out_dm_reg, out_dm_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;

    logic [LEVEL_W-1:0]  ring_mem [WINDOW_MAX];
    logic [LEVEL_W-1:0]  ring_q_reg;
    logic [RING_AW-1:0]  ring_rd_addr;
    logic                ring_we;

    hist_req_t           hreq;
    logic [COUNT_W-1:0]  hist_q;

    logic [WIN_W-1:0]    win_eff;
    logic [WIN_W-1:0]    mid;
    logic [SEEN_W-1:0]   sum;
    logic                fin;
    logic [DM_W-1:0]     dmv;
    logic                alert_now;
    logic [WIN_W-1:0]    fill_eff;

    swma_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .q     (hist_q)
    );

    // window length zero acts as one, above the ring depth saturates
    always_comb
    begin
        if (win_len_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (win_len_reg > WIN_W'(WINDOW_MAX))
        begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = win_len_reg;
        end
    end

    assign mid          = {1'b0, win_eff[WIN_W-1:1]} + {{(WIN_W-1){1'b0}}, win_eff[0]};
    assign ring_rd_addr = ring_pos_reg - win_eff[RING_AW-1:0];
    assign sum          = seen_reg + {1'b0, hist_q};
    assign alert_now    = ({1'b0, smp_reg} >= dmv);

    assign cfg.ready      = (state_reg == ST_IDLE);
    assign samples.ready  = (state_reg == ST_IDLE) && !cfg.valid;
    assign results.valid          = out_valid_reg;
    assign results.alert          = out_alert_reg;
    assign results.doubled_median = out_dm_reg;
    assign results.alert_total    = out_total_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_pos_reg] <= smp_reg;
        end
        ring_q_reg <= ring_mem[ring_rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        win_len_next    = win_len_reg;
        ring_pos_next   = ring_pos_reg;
        fill_next       = fill_reg;
        alert_cnt_next  = alert_cnt_reg;
        filling_next    = filling_reg;
        scan_next_next  = scan_next_reg;
        scan_prime_next = scan_prime_reg;
        second_next     = second_reg;
        smp_next        = smp_reg;
        cur_idx_next    = cur_idx_reg;
        lo_next         = lo_reg;
        seen_next       = seen_reg;
        dm_next         = dm_reg;
        alert_next      = alert_reg;
        out_alert_next  = out_alert_reg;
        out_dm_next     = out_dm_reg;
        out_total_next  = out_total_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        ring_we         = 1'b0;
        fin             = 1'b0;
        dmv             = '0;
        fill_eff        = fill_reg;
        hreq.clear      = 1'b0;
        hreq.wr_en      = 1'b0;
        hreq.addr       = scan_next_reg[LEVEL_W-1:0];
        hreq.wr_data    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg.valid)
                begin
                    win_len_next   = cfg.window_length;
                    hreq.clear     = 1'b1;
                    ring_pos_next  = '0;
                    fill_next      = '0;
                    alert_cnt_next = '0;
                end
                else if (samples.valid)
                begin
                    smp_next = samples.sample;
                    if (samples.start_of_sequence)
                    begin
                        hreq.clear     = 1'b1;
                        ring_pos_next  = '0;
                        fill_next      = '0;
                        alert_cnt_next = '0;
                        fill_eff       = '0;
                    end
                    filling_next    = (fill_eff < win_eff);
                    scan_next_next  = '0;
                    scan_prime_next = 1'b1;
                    second_next     = 1'b0;
                    seen_next       = '0;
                    state_next      = (fill_eff < win_eff) ? ST_NEW_RD : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue bin scan_next, evaluate the bin read last cycle
                hreq.addr       = scan_next_reg[LEVEL_W-1:0];
                cur_idx_next    = scan_next_reg[LEVEL_W-1:0];
                scan_prime_next = 1'b0;
                if (!scan_next_reg[LEVEL_W])
                begin
                    scan_next_next = scan_next_reg + 1'b1;
                end
                if (!scan_prime_reg)
                begin
                    if (!second_reg)
                    begin
                        seen_next = sum;
                        if (sum > SEEN_W'(mid))
                        begin
                            fin = 1'b1;
                            dmv = {cur_idx_reg, 1'b0};
                        end
                        else if (sum == SEEN_W'(mid))
                        begin
                            if (win_eff[0])
                            begin
                                fin = 1'b1;
                                dmv = {cur_idx_reg, 1'b0};
                            end
                            else
                            begin
                                // even window: look for the next occupied bin
                                second_next = 1'b1;
                                lo_next     = cur_idx_reg;
                            end
                        end
                    end
                    else if (hist_q != '0)
                    begin
                        fin = 1'b1;
                        dmv = {1'b0, lo_reg} + {1'b0, cur_idx_reg};
                    end

                    if (!fin && (cur_idx_reg == LEVEL_W'(VALUE_LEVELS - 1)))
                    begin
                        fin = 1'b1;
                        if (second_reg)
                        begin
                            dmv = {lo_reg, 1'b0};
                        end
                        else if (sum == SEEN_W'(mid))
                        begin
                            dmv = {cur_idx_reg, 1'b0};
                        end
                        else
                        begin
                            dmv = '0;
                        end
                    end

                    if (fin)
                    begin
                        dm_next    = dmv;
                        alert_next = alert_now;
                        if (alert_now && (alert_cnt_reg != '1))
                        begin
                            alert_cnt_next = alert_cnt_reg + 1'b1;
                        end
                        state_next = ST_OLD_RD;
                    end
                end
            end

            ST_OLD_RD:
            begin
                // ring read of the oldest sample is in flight
                state_next = ST_OLD_HRD;
            end

            ST_OLD_HRD:
            begin
                hreq.addr  = ring_q_reg;
                state_next = ST_OLD_WR;
            end

            ST_OLD_WR:
            begin
                hreq.addr = ring_q_reg;
                if (hist_q != '0)
                begin
                    hreq.wr_en   = 1'b1;
                    hreq.wr_data = hist_q - 1'b1;
                end
                state_next = ST_NEW_RD;
            end

            ST_NEW_RD:
            begin
                hreq.addr     = smp_reg;
                ring_we       = 1'b1;
                ring_pos_next = ring_pos_reg + 1'b1;
                state_next    = ST_NEW_WR;
            end

            ST_NEW_WR:
            begin
                hreq.addr    = smp_reg;
                hreq.wr_en   = 1'b1;
                hreq.wr_data = hist_q + 1'b1;
                if (filling_reg)
                begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_alert_next = alert_reg;
                    out_dm_next    = dm_reg;
                    out_total_next = alert_cnt_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_len_reg    <= WIN_W'(1);
            ring_pos_reg   <= '0;
            fill_reg       <= '0;
            alert_cnt_reg  <= '0;
            filling_reg    <= 1'b0;
            scan_next_reg  <= '0;
            scan_prime_reg <= 1'b0;
            second_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_len_reg    <= win_len_next;
            ring_pos_reg   <= ring_pos_next;
            fill_reg       <= fill_next;
            alert_cnt_reg  <= alert_cnt_next;
            filling_reg    <= filling_next;
            scan_next_reg  <= scan_next_next;
            scan_prime_reg <= scan_prime_next;
            second_reg     <= second_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg       <= smp_next;
        cur_idx_reg   <= cur_idx_next;
        lo_reg        <= lo_next;
        seen_reg      <= seen_next;
        dm_reg        <= dm_next;
        alert_reg     <= alert_next;
        out_alert_reg <= out_alert_next;
        out_dm_reg    <= out_dm_next;
        out_total_reg <= out_total_next;
    end

    `SWMA_ASSERT(a_fill_bound, fill_reg <= win_eff, "fill count beyond window length")
    `SWMA_ASSERT(a_busy_after_req,
                 samples.valid && samples.ready |=> !samples.ready,
                 "ready right after sample request")
    `SWMA_ASSERT(a_cfg_restarts,
                 cfg.valid && cfg.ready |=> fill_reg == '0 && alert_cnt_reg == '0,
                 "config write did not restart window")
    `SWMA_ASSERT_ALWAYS(a_alert_counted,
                        !rst_n || !results.valid || !results.alert || results.alert_total != '0,
                        "alert result with zero total")

endmodule

/* test/sliding_window_median_alert_top_tb.sv */
// self-checking bench for the sliding window median alert top level
// uses swma_pkg and the three channel interfaces; results are predicted from a
// software copy of histogram, sample ring and alert count
`timescale 1ns / 1ps

module sliding_window_median_alert_top_tb;
    import swma_pkg::*;

    localparam int    SETTLE_CYCLES = 16;
    localparam int    DRAIN_CYCLES  = 300;
    localparam int    LONG_HOLD     = 1500;
    localparam int    HOLD_AT       = 120;
    localparam longint RUN_LIMIT_NS = 64'd50_000_000;

    typedef struct packed {
        logic [LEVEL_W-1:0] value;
        logic               restart;
    } sample_req_t;

    typedef struct packed {
        logic               alert;
        logic [DM_W-1:0]    doubled_median;
        logic [TOTAL_W-1:0] alert_total;
    } median_verdict_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PATCHY,
        RX_CHOKED
    } rx_mode_t;

    typedef enum int {
        MIX_UNIFORM,
        MIX_SPIKY,
        MIX_FLAT
    } sample_mix_t;

    logic clk;
    logic rst_n = 1'b0;

    swma_cfg_if    cfg_bus ();
    swma_sample_if sample_bus ();
    swma_result_if result_bus ();

    sliding_window_median_alert_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .samples (sample_bus),
        .results (result_bus)
    );

    // shadow of the block's state
    logic [WIN_W-1:0]   window_reg;
    logic [COUNT_W-1:0] bin_count [VALUE_LEVELS];
    logic [LEVEL_W-1:0] held_samples [WINDOW_MAX];
    logic [RING_AW-1:0] write_slot;
    logic [COUNT_W-1:0] samples_held;
    logic [TOTAL_W-1:0] alerts_so_far;

    sample_req_t     samples_to_send [$];
    median_verdict_t verdicts_due [$];

    int failures         = 0;
    int items_sent       = 0;
    int verdicts_checked = 0;
    int alerts_seen      = 0;
    int windows_tried    = 0;
    int burst_left       = 1;
    int gap_left         = 0;
    int hold_left        = 0;
    int mode_left        = 0;
    int verdicts_taken   = 0;
    bit long_hold_done   = 1'b0;

    rx_mode_t        rx_mode = RX_OPEN;
    sample_req_t     head_item;
    median_verdict_t want;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("sliding_window_median_alert_top_tb failed");
        $finish;
    end

    function automatic void clear_window();
        for (int i = 0; i < VALUE_LEVELS; i++)
            bin_count[i] = '0;
        write_slot    = '0;
        samples_held  = '0;
        alerts_so_far = '0;
    endfunction

    function automatic int unsigned live_window();
        if (window_reg == 0)
            return 1;
        if (window_reg > WINDOW_MAX)
            return WINDOW_MAX;
        return window_reg;
    endfunction

    // histogram walk: odd windows take the middle bin, even ones add the next occupied bin
    function automatic int unsigned twice_median(int unsigned w);
        bit          even_w;
        int unsigned target;
        int unsigned running;
        even_w  = (w % 2) == 0;
        target  = w / 2 + (even_w ? 0 : 1);
        running = 0;
        for (int unsigned i = 0; i < VALUE_LEVELS; i++)
        begin
            running += bin_count[i];
            if (running > target)
                return 2 * i;
            if (running == target)
            begin
                if (!even_w)
                    return 2 * i;
                for (int unsigned j = i + 1; j < VALUE_LEVELS; j++)
                    if (bin_count[j] != 0)
                        return i + j;
                return 2 * i;
            end
        end
        return 0;
    endfunction

    task automatic take_sample(input logic [LEVEL_W-1:0] value, input logic restart);
        int unsigned     w;
        int unsigned     dm;
        int unsigned     oldest;
        logic [LEVEL_W-1:0] leaving;
        median_verdict_t v;
        w = live_window();
        if (restart)
            clear_window();
        if (samples_held < w)
        begin
            held_samples[write_slot] = value;
            write_slot = write_slot + 1'b1;
            bin_count[value] = bin_count[value] + 1'b1;
            samples_held = samples_held + 1'b1;
        end
        else
        begin
            dm = twice_median(w);
            v.alert = (value >= dm);
            if (v.alert && alerts_so_far != '1)
                alerts_so_far = alerts_so_far + 1'b1;
            oldest  = (write_slot + WINDOW_MAX - w) % WINDOW_MAX;
            leaving = held_samples[oldest];
            if (bin_count[leaving] != 0)
                bin_count[leaving] = bin_count[leaving] - 1'b1;
            held_samples[write_slot] = value;
            write_slot = write_slot + 1'b1;
            bin_count[value] = bin_count[value] + 1'b1;
            v.doubled_median = (dm > 511) ? 9'd511 : dm[DM_W-1:0];
            v.alert_total    = alerts_so_far;
            verdicts_due = {verdicts_due, v};
        end
    endtask

    // sample driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bus.valid             <= 1'b0;
            sample_bus.sample            <= '0;
            sample_bus.start_of_sequence <= 1'b0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
            begin
                take_sample(sample_bus.sample, sample_bus.start_of_sequence);
                items_sent++;
            end
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_bus.valid <= 1'b0;
                end
                else if (samples_to_send.size() > 0)
                begin
                    head_item = samples_to_send.pop_front();
                    sample_bus.valid             <= 1'b1;
                    sample_bus.sample            <= head_item.value;
                    sample_bus.start_of_sequence <= head_item.restart;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 5) == 0)
                        begin
                            burst_left = $urandom_range(50, 200);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 20);
                            gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120)
                                                                     : $urandom_range(0, 4);
                        end
                    end
                end
                else
                    sample_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver: changing stall pattern, plus one long hold-off to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
                verdicts_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (!long_hold_done && verdicts_taken == HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(32, 600);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_OPEN:   result_bus.ready <= 1'b1;
                    RX_PATCHY: result_bus.ready <= 1'($urandom_range(0, 1));
                    default:   result_bus.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected result: alert %0d, doubled_median %0d, alert_total %0d",
                       result_bus.alert, result_bus.doubled_median, result_bus.alert_total);
                failures++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (result_bus.alert !== want.alert)
                begin
                    $error("alert: expected %0d, got %0d", want.alert, result_bus.alert);
                    failures++;
                end
                if (result_bus.doubled_median !== want.doubled_median)
                begin
                    $error("doubled_median: expected %0d, got %0d",
                           want.doubled_median, result_bus.doubled_median);
                    failures++;
                end
                if (result_bus.alert_total !== want.alert_total)
                begin
                    $error("alert_total: expected %0d, got %0d",
                           want.alert_total, result_bus.alert_total);
                    failures++;
                end
                verdicts_checked++;
                if (want.alert)
                    alerts_seen++;
            end
        end
    end

    task automatic write_window(input logic [WIN_W-1:0] len);
        @(posedge clk);
        cfg_bus.window_length <= len;
        cfg_bus.valid         <= 1'b1;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        // a length write restarts the window
        window_reg = len;
        clear_window();
        windows_tried++;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic queue_sample(input logic [LEVEL_W-1:0] value, input logic restart);
        sample_req_t r;
        r.value   = value;
        r.restart = restart;
        samples_to_send = {samples_to_send, r};
    endtask

    // fill-only requests give no result, so keep waiting for the settle count after the queue runs dry
    task automatic wait_until_idle(input int settle);
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || sample_bus.valid || verdicts_due.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    function automatic logic [LEVEL_W-1:0] pick_sample(sample_mix_t mix);
        case (mix)
            MIX_UNIFORM: return LEVEL_W'($urandom_range(0, 255));
            MIX_SPIKY:
            begin
                if ($urandom_range(0, 9) == 0)
                    return LEVEL_W'($urandom_range(60, 255));
                return LEVEL_W'($urandom_range(0, 40));
            end
            default:
            begin
                if ($urandom_range(0, 7) == 0)
                    return LEVEL_W'($urandom_range(0, 255));
                return LEVEL_W'($urandom_range(0, 3));
            end
        endcase
    endfunction

    int unsigned window_plan [9] = '{1, 2, 6, 3, 16, 7, 128, 47, 5};
    int unsigned span;
    int unsigned wanted;

    initial
    begin
        cfg_bus.valid                = 1'b0;
        cfg_bus.window_length        = '0;
        window_reg = 1;
        for (int i = 0; i < WINDOW_MAX; i++)
            held_samples[i] = '0;
        clear_window();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // zero length acts as a window of one
        write_window(WIN_W'(0));
        @(negedge clk);
        queue_sample(8'd5, 1'b1);
        queue_sample(8'd10, 1'b0);
        queue_sample(8'd19, 1'b0);
        queue_sample(8'd255, 1'b0);
        queue_sample(8'd0, 1'b0);
        wait_until_idle(SETTLE_CYCLES);

        // even window: median between extremes, sample equal to the reference, restart
        write_window(WIN_W'(4));
        @(negedge clk);
        queue_sample(8'd255, 1'b0);
        queue_sample(8'd255, 1'b0);
        queue_sample(8'd0, 1'b0);
        queue_sample(8'd0, 1'b0);
        queue_sample(8'd255, 1'b0);
        queue_sample(8'd0, 1'b0);
        queue_sample(8'd128, 1'b1);
        queue_sample(8'd0, 1'b0);
        queue_sample(8'd0, 1'b0);
        queue_sample(8'd0, 1'b0);
        queue_sample(8'd0, 1'b0);
        wait_until_idle(SETTLE_CYCLES);

        write_window(WIN_W'(3));
        @(negedge clk);
        queue_sample(8'd100, 1'b0);
        queue_sample(8'd1, 1'b0);
        queue_sample(8'd200, 1'b0);
        queue_sample(8'd200, 1'b0);
        queue_sample(8'd99, 1'b0);
        queue_sample(8'd200, 1'b0);
        wait_until_idle(SETTLE_CYCLES);

        // random sequences over a spread of window lengths
        foreach (window_plan[p])
        begin
            write_window(WIN_W'(window_plan[p]));
            span   = live_window();
            wanted = (span >= 512) ? $urandom_range(15, 25) : $urandom_range(50, 70);
            @(negedge clk);
            for (int unsigned k = 0; k < span + wanted; k++)
                queue_sample(pick_sample(sample_mix_t'(p % 3)),
                             (span < 512) && ($urandom_range(0, 79) == 0));
            wait_until_idle(SETTLE_CYCLES);
        end

        wait_until_idle(DRAIN_CYCLES);
        $display("%0d sample requests over %0d window lengths (0 to 128)", items_sent,
                 windows_tried);
        $display("%0d results checked, %0d flagged, input backed up behind one long stall",
                 verdicts_checked, alerts_seen);
        if (failures == 0 && verdicts_due.size() == 0)
            $display("sliding_window_median_alert_top_tb passed");
        else
            $display("sliding_window_median_alert_top_tb failed");
        $finish;
    end

endmodule
